/* rtl/rgc_pkg.sv */
// ----------------------------------------------------------------------------
// rgc_pkg: readability grade counter shared definitions
// Widths, character codes, band codes, controller states, command and
// status structs, and character class helpers.
// ----------------------------------------------------------------------------
package rgc_pkg;

	localparam int COUNT_BITS = 16;
	localparam int FIELD_BITS = 16;
	localparam int FIELD_MAX  = 65535;
	// signed numerator with room for the doubling and rounding offset
	localparam int NUM_W      = COUNT_BITS + 16;
	localparam int QUO_W      = 5;
	localparam int QUO_CAP    = 17;
	localparam int GRADE_MAX  = 16;
	localparam int MUL_LETTER = 588;
	localparam int MUL_SENT   = 2960;
	localparam int MUL_WORD   = 1580;
	localparam int MUL_DEN    = 100;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_QUERY = 8'h3F;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [FIELD_BITS-1:0] field_t;
	typedef logic [NUM_W-1:0]      num_t;
	typedef logic [QUO_W-1:0]      quo_t;
	typedef logic [1:0]            band_t;

	localparam band_t BAND_BELOW  = 2'd0;
	localparam band_t BAND_GRADED = 2'd1;
	localparam band_t BAND_ABOVE  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUB,
		ST_PREP,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic count;
		logic mul;
		logic sub;
		logic prep;
		logic div;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} status_t;

	function automatic logic is_letter(logic [7:0] c);
		return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_stop(logic [7:0] c);
		return (c == CH_DOT) || (c == CH_BANG) || (c == CH_QUERY);
	endfunction

	function automatic count_t sat_inc(count_t v);
		return (v == '1) ? v : v + count_t'(1);
	endfunction

	function automatic field_t to_field(count_t v);
		if (32'(v) > FIELD_MAX)
			return field_t'(FIELD_MAX);
		return field_t'(v);
	endfunction

endpackage

/* rtl/rgc_char_if.sv */
// ----------------------------------------------------------------------------
// rgc_char_if: character input channel
// One text byte per transaction with a last-byte mark.
// ----------------------------------------------------------------------------
interface rgc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       last_char;

	modport source (output valid, output char_byte, output last_char, input ready);
	modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

/* rtl/rgc_grade_if.sv */
// ----------------------------------------------------------------------------
// rgc_grade_if: grade result channel
// One grade and the three totals per transaction.
// ----------------------------------------------------------------------------
interface rgc_grade_if;
	logic        valid;
	logic        ready;
	logic [1:0]  band;
	logic [4:0]  grade;
	logic [15:0] letter_total;
	logic [15:0] word_total;
	logic [15:0] sentence_total;

	modport source (output valid, output band, output grade, output letter_total,
		output word_total, output sentence_total, input ready);
	modport sink   (input valid, input band, input grade, input letter_total,
		input word_total, input sentence_total, output ready);
endinterface

/* rtl/readability_grade_counter_unit.sv */
// ----------------------------------------------------------------------------
// readability_grade_counter_unit: Coleman-Liau readability grade
// Counts letters, words and sentences over a byte stream and gives the
// rounded, banded grade with the totals after the last byte.
//
//   channel  dir  handshake    payload
//   chars    in   valid/ready  char_byte[7:0], last_char
//   grades   out  valid/ready  band[1:0], grade[4:0], letter_total,
//                              word_total, sentence_total [15:0]
//
// Ordinary bytes: one per cycle. After the last byte the input stalls for
// the three arithmetic steps, one subtract per grade unit in the repeated
// subtract unit (at most seventeen), and the result load.
// The result register frees the input once loaded; a held result stalls
// only the load of the next one. Reset clears counters, flags and valid.
// ----------------------------------------------------------------------------
module readability_grade_counter_unit (
	input  logic        clk,
	input  logic        arst_n,
	rgc_char_if.sink    chars,
	rgc_grade_if.source grades
);
	import rgc_pkg::*;

	cmd_t    cmd;
	status_t status;

	rgc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_valid  (chars.valid),
		.char_last   (chars.last_char),
		.char_ready  (chars.ready),
		.grade_ready (grades.ready),
		.grade_valid (grades.valid),
		.cmd         (cmd),
		.status      (status)
	);

	rgc_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.char_byte      (chars.char_byte),
		.band           (grades.band),
		.grade          (grades.grade),
		.letter_total   (grades.letter_total),
		.word_total     (grades.word_total),
		.sentence_total (grades.sentence_total)
	);

	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		chars.valid && chars.ready && chars.last_char |=> !chars.ready)
		else $error("input taken during grade computation");

	a_below_grade: assert property (@(posedge clk) disable iff (!arst_n)
		grades.valid && grades.band == BAND_BELOW |-> grades.grade == 5'd1)
		else $error("below band without grade one");

	a_above_grade: assert property (@(posedge clk) disable iff (!arst_n)
		grades.valid && grades.band == BAND_ABOVE |-> grades.grade == 5'd16)
		else $error("above band without grade sixteen");

	a_graded_range: assert property (@(posedge clk) disable iff (!arst_n)
		grades.valid |-> grades.band == BAND_BELOW || grades.band == BAND_ABOVE
			|| (grades.band == BAND_GRADED && grades.grade != 5'd0
			&& grades.grade <= 5'd16))
		else $error("grade outside band range");
endmodule

/* rtl/rgc_ctrl.sv */
// ----------------------------------------------------------------------------
// rgc_ctrl: readability grade counter controller
// Sequences counting, the grade arithmetic steps and the result load, and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module rgc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             char_valid,
	input  logic             char_last,
	output logic             char_ready,
	input  logic             grade_ready,
	output logic             grade_valid,
	output rgc_pkg::cmd_t    cmd,
	input  rgc_pkg::status_t status
);
	import rgc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				out_valid_q <= 1'b1;
			else if (grade_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		char_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				char_ready = 1'b1;
				cmd.count  = char_valid;
				if (char_valid && char_last)
					state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUB;
			end
			ST_SUB: begin
				cmd.sub = 1'b1;
				state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done)
					state_d = ST_OUT;
				else
					cmd.div = 1'b1;
			end
			ST_OUT: begin
				if (!out_valid_q || grade_ready) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign grade_valid = out_valid_q;
endmodule

/* rtl/rgc_dpath.sv */
// ----------------------------------------------------------------------------
// rgc_dpath: readability grade counter datapath
// Saturating counters and run flags, constant products, and a repeated
// subtract unit that finds the rounded quotient capped at seventeen.
// ----------------------------------------------------------------------------
module rgc_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  rgc_pkg::cmd_t     cmd,
	output rgc_pkg::status_t  status,
	input  logic [7:0]        char_byte,
	output rgc_pkg::band_t    band,
	output logic [4:0]        grade,
	output rgc_pkg::field_t   letter_total,
	output rgc_pkg::field_t   word_total,
	output rgc_pkg::field_t   sentence_total
);
	import rgc_pkg::*;

	count_t letter_q, word_q, sentence_q;
	logic   in_word_q, in_punct_q;

	num_t   a_q, b_q, c_q, h_q, acc_q, rem_q;
	logic   neg_q;
	quo_t   quo_q;

	band_t  band_q;
	logic [4:0] grade_q;
	field_t letter_tot_q, word_tot_q, sentence_tot_q;

	num_t   den2;
	logic   word_zero;
	logic   can_sub;

	assign den2      = {h_q[NUM_W-2:0], 1'b0};
	assign word_zero = (word_q == '0);
	assign can_sub   = (rem_q >= den2) && (quo_q != quo_t'(QUO_CAP));
	assign status.div_done = word_zero || neg_q || !can_sub;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			letter_q   <= '0;
			word_q     <= '0;
			sentence_q <= '0;
			in_word_q  <= 1'b0;
			in_punct_q <= 1'b0;
		end else if (cmd.load) begin
			letter_q   <= '0;
			word_q     <= '0;
			sentence_q <= '0;
			in_word_q  <= 1'b0;
			in_punct_q <= 1'b0;
		end else if (cmd.count) begin
			if (is_letter(char_byte))
				letter_q <= sat_inc(letter_q);
			if (is_blank(char_byte)) begin
				in_word_q <= 1'b0;
			end else begin
				if (!in_word_q)
					word_q <= sat_inc(word_q);
				in_word_q <= 1'b1;
			end
			if (is_stop(char_byte)) begin
				if (!in_punct_q)
					sentence_q <= sat_inc(sentence_q);
				in_punct_q <= 1'b1;
			end else begin
				in_punct_q <= 1'b0;
			end
		end
	end

	// arithmetic and result payload
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			a_q <= num_t'(letter_q) * num_t'(MUL_LETTER);
			b_q <= num_t'(sentence_q) * num_t'(MUL_SENT);
			c_q <= num_t'(word_q) * num_t'(MUL_WORD);
			h_q <= num_t'(word_q) * num_t'(MUL_DEN);
		end
		if (cmd.sub)
			acc_q <= a_q - b_q - c_q;
		if (cmd.prep) begin
			neg_q <= acc_q[NUM_W-1];
			rem_q <= {acc_q[NUM_W-2:0], 1'b0} + h_q;
			quo_q <= '0;
		end
		if (cmd.div) begin
			rem_q <= rem_q - den2;
			quo_q <= quo_q + quo_t'(1);
		end
		if (cmd.load) begin
			if (word_zero || neg_q || quo_q == '0) begin
				band_q  <= BAND_BELOW;
				grade_q <= 5'd1;
			end else if (quo_q == quo_t'(QUO_CAP)) begin
				band_q  <= BAND_ABOVE;
				grade_q <= 5'(GRADE_MAX);
			end else begin
				band_q  <= BAND_GRADED;
				grade_q <= 5'(quo_q);
			end
			letter_tot_q   <= to_field(letter_q);
			word_tot_q     <= to_field(word_q);
			sentence_tot_q <= to_field(sentence_q);
		end
	end

	assign band           = band_q;
	assign grade          = grade_q;
	assign letter_total   = letter_tot_q;
	assign word_total     = word_tot_q;
	assign sentence_total = sentence_tot_q;
endmodule
